// ===== rtl/gcdc_pkg.sv =====
// Shared types, codes and constants for the grid cell disk collision core.
// No dependencies.
package gcdc_pkg;

  localparam int MAX_DISKS_DEF = 4096;
  localparam int GRID_SIDE_DEF = 64;

  localparam int POS_W      = 24;
  localparam int RAD_W      = 16;
  localparam int HB_W       = 23;
  localparam int GL_W       = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PROBE_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_BOX     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_LENGTH  = 2'd3;

  // neighbor offsets per axis
  localparam logic [1:0] OFF_M = 2'd0;
  localparam logic [1:0] OFF_Z = 2'd1;
  localparam logic [1:0] OFF_P = 2'd2;
  localparam logic [3:0] NB_COUNT = 4'd9;

  typedef struct packed {
    logic [1:0]              cmd;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [RAD_W-1:0]        disk_radius;
  } in_item_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       sweep_init;
    logic       sweep;
    logic       div_start;
    logic       div_axis;
    logic       ins_wr;
    logic       nb_next;
    logic       link_load;
    logic       latch_disk;
    logic       sq_x;
    logic       sq_y;
    logic       sq_c;
    logic       set_hit;
    logic       set_status;
    logic [1:0] status_code;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       full;
    logic       sweep_last;
    logic       div_done;
    logic       outside;
    logic       nb_end;
    logic       nb_ok;
    logic       link_zero;
    logic       is_hit;
  } dp_stat_t;

  // search order: home cell, then row-major over the 3x3 neighborhood
  function automatic logic [1:0] nb_row(input logic [3:0] n);
    logic [1:0] r;
    case (n)
      4'd1, 4'd2, 4'd3: r = OFF_M;
      4'd6, 4'd7, 4'd8: r = OFF_P;
      default:          r = OFF_Z;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] nb_col(input logic [3:0] n);
    logic [1:0] c;
    case (n)
      4'd1, 4'd4, 4'd6: c = OFF_M;
      4'd3, 4'd5, 4'd8: c = OFF_P;
      default:          c = OFF_Z;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/gcdc_ram.sv =====
// Generic single-port RAM, one write or read per cycle, registered read data.
// No dependencies.
module gcdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/gcdc_dp.sv =====
// Datapath: config registers, cell divider, list RAMs, distance test, result register.
// Depends on gcdc_pkg and gcdc_ram.
module gcdc_dp import gcdc_pkg::*; #(
  parameter int MAX_DISKS = MAX_DISKS_DEF,
  parameter int GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_item_t              in_data,
  input  logic                  cfg_wr,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output out_item_t             out_data
);

  localparam int NCELLS  = GRID_SIDE * GRID_SIDE;
  localparam int CELL_AW = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int IDX_W   = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int LEN_W   = $clog2(GRID_SIDE + 1);
  localparam int CMP_W   = (LEN_W > GL_W) ? LEN_W : GL_W;
  localparam int NW      = LEN_W + 1;
  localparam int LINK_W  = $clog2(MAX_DISKS + 1);
  localparam int DISK_AW = (MAX_DISKS > 1) ? $clog2(MAX_DISKS) : 1;
  localparam int DISK_W  = LINK_W + 2 * POS_W + RAD_W;
  localparam int CNT_W   = $clog2(POS_W + 1);
  localparam int SQ_W    = 2 * POS_W;

  // configuration
  logic [RAD_W-1:0] probe_radius_r;
  logic [RAD_W-1:0] cell_size_r;
  logic [HB_W-1:0]  half_box_r;
  logic [GL_W-1:0]  grid_length_r;

  // item
  logic [1:0]              cmd_r;
  logic signed [POS_W-1:0] x_r, y_r;
  logic [RAD_W-1:0]        rad_r;
  logic                    hit_r;
  logic [1:0]              status_r;
  out_item_t               out_r;

  logic [LINK_W-1:0]  count_r;
  logic [CELL_AW-1:0] sweep_addr_r;

  // divider
  logic             div_busy_r;
  logic             div_axis_r;
  logic [CNT_W-1:0] div_cnt_r;
  logic [POS_W-1:0] dvd_r;
  logic [RAD_W-1:0] rem_r;
  logic             outside_r;
  logic [IDX_W-1:0] ci_r, cj_r;

  // list walk
  logic [3:0]        nb_r;
  logic [LINK_W-1:0] link_r;
  logic [POS_W-1:0]  adx_r, ady_r;
  logic [RAD_W:0]    c_r;
  logic [SQ_W-1:0]   prod_r;
  logic [SQ_W:0]     acc_r;

  // effective grid length
  logic [CMP_W-1:0] gl_ext, side_ext, eff_ext;
  logic [LEN_W-1:0] len;
  assign gl_ext   = CMP_W'(grid_length_r);
  assign side_ext = CMP_W'(GRID_SIDE);
  assign eff_ext  = (gl_ext > side_ext) ? side_ext : gl_ext;
  assign len      = eff_ext[LEN_W-1:0];

  // divider step
  logic [RAD_W-1:0] cs;
  logic [RAD_W:0]   div_t, div_sub;
  logic             div_ge;
  logic [POS_W-1:0] quo;
  logic [POS_W:0]   s_sum;
  logic [POS_W-1:0] s_pos;
  assign cs      = (cell_size_r == '0) ? RAD_W'(1) : cell_size_r;
  assign div_t   = {rem_r, dvd_r[POS_W-1]};
  assign div_sub = div_t - {1'b0, cs};
  assign div_ge  = (div_t >= {1'b0, cs});
  assign quo     = {dvd_r[POS_W-2:0], div_ge};
  assign s_pos   = cmd.div_axis ? y_r : x_r;
  assign s_sum   = {s_pos[POS_W-1], s_pos} + (POS_W + 1)'(half_box_r);

  // neighbor cell
  logic [1:0]         rsel, csel;
  logic [NW-1:0]      ci_w, cj_w, len_w;
  logic               row_ok, col_ok;
  logic [IDX_W-1:0]   ni, nj;
  logic [IDX_W+LEN_W-1:0] cell_full;
  logic [CELL_AW-1:0] cell_addr;
  assign rsel  = nb_row(nb_r);
  assign csel  = nb_col(nb_r);
  assign ci_w  = NW'(ci_r);
  assign cj_w  = NW'(cj_r);
  assign len_w = NW'(len);

  always_comb begin
    row_ok = 1'b1;
    col_ok = 1'b1;
    ni = ci_r;
    nj = cj_r;
    case (rsel)
      OFF_M: begin
        row_ok = (ci_r != '0);
        ni = ci_r - IDX_W'(1);
      end
      OFF_P: begin
        row_ok = (ci_w + NW'(1)) < len_w;
        ni = ci_r + IDX_W'(1);
      end
      default: ;
    endcase
    case (csel)
      OFF_M: begin
        col_ok = (cj_r != '0);
        nj = cj_r - IDX_W'(1);
      end
      OFF_P: begin
        col_ok = (cj_w + NW'(1)) < len_w;
        nj = cj_r + IDX_W'(1);
      end
      default: ;
    endcase
  end

  assign cell_full = ni * len + (IDX_W + LEN_W)'(nj);
  assign cell_addr = cell_full[CELL_AW-1:0];

  // memories
  logic               head_we;
  logic [CELL_AW-1:0] head_addr;
  logic [LINK_W-1:0]  head_wdata, head_rdata;
  logic [LINK_W-1:0]  count_p1;
  assign count_p1   = count_r + LINK_W'(1);
  assign head_we    = cmd.sweep | cmd.ins_wr;
  assign head_addr  = cmd.sweep ? sweep_addr_r : cell_addr;
  assign head_wdata = cmd.sweep ? '0 : count_p1;

  gcdc_ram #(.WIDTH(LINK_W), .DEPTH(NCELLS)) u_head (
    .clk   (clk),
    .we    (head_we),
    .addr  (head_addr),
    .wdata (head_wdata),
    .rdata (head_rdata)
  );

  logic [LINK_W-1:0]  link_m1;
  logic [DISK_AW-1:0] disk_addr;
  logic [DISK_W-1:0]  disk_wdata, disk_rdata;
  assign link_m1    = link_r - LINK_W'(1);
  assign disk_addr  = cmd.ins_wr ? count_r[DISK_AW-1:0] : link_m1[DISK_AW-1:0];
  assign disk_wdata = {head_rdata, x_r, y_r, rad_r};

  gcdc_ram #(.WIDTH(DISK_W), .DEPTH(MAX_DISKS)) u_disk (
    .clk   (clk),
    .we    (cmd.ins_wr),
    .addr  (disk_addr),
    .wdata (disk_wdata),
    .rdata (disk_rdata)
  );

  // distance terms from the fetched disk
  logic [LINK_W-1:0]       d_next;
  logic signed [POS_W-1:0] d_x, d_y;
  logic [RAD_W-1:0]        d_rad;
  logic signed [POS_W:0]   dx, dy;
  logic [POS_W:0]          adx, ady;
  assign {d_next, d_x, d_y, d_rad} = disk_rdata;
  assign dx  = {x_r[POS_W-1], x_r} - {d_x[POS_W-1], d_x};
  assign dy  = {y_r[POS_W-1], y_r} - {d_y[POS_W-1], d_y};
  assign adx = dx[POS_W] ? -dx : dx;
  assign ady = dy[POS_W] ? -dy : dy;

  logic [POS_W-1:0] mul_a;
  logic [SQ_W-1:0]  mul_p;
  always_comb begin
    if (cmd.sq_x) begin
      mul_a = adx_r;
    end else if (cmd.sq_y) begin
      mul_a = ady_r;
    end else begin
      mul_a = POS_W'(c_r);
    end
  end
  assign mul_p = mul_a * mul_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_radius_r <= '0;
      cell_size_r    <= RAD_W'(256);
      half_box_r     <= '0;
      grid_length_r  <= GL_W'(64);
      count_r        <= '0;
      sweep_addr_r   <= '0;
      div_busy_r     <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_index)
          REG_PROBE_RADIUS: probe_radius_r <= cfg_data[RAD_W-1:0];
          REG_CELL_SIZE:    cell_size_r    <= cfg_data[RAD_W-1:0];
          REG_HALF_BOX:     half_box_r     <= cfg_data[HB_W-1:0];
          REG_GRID_LENGTH:  grid_length_r  <= cfg_data[GL_W-1:0];
          default: ;
        endcase
      end
      if (cmd.sweep_init) begin
        sweep_addr_r <= '0;
        count_r      <= '0;
      end else if (cmd.sweep) begin
        sweep_addr_r <= sweep_addr_r + CELL_AW'(1);
      end else if (cmd.ins_wr) begin
        count_r <= count_p1;
      end
      if (cmd.div_start) begin
        div_busy_r <= 1'b1;
      end else if (div_busy_r && div_cnt_r == CNT_W'(1)) begin
        div_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r     <= in_data.cmd;
      x_r       <= in_data.pos_x;
      y_r       <= in_data.pos_y;
      rad_r     <= in_data.disk_radius;
      hit_r     <= 1'b0;
      status_r  <= ST_OK;
      outside_r <= 1'b0;
      nb_r      <= '0;
    end else begin
      if (cmd.set_hit) hit_r <= 1'b1;
      if (cmd.set_status) status_r <= cmd.status_code;
      if (cmd.nb_next) nb_r <= nb_r + 4'd1;
      if (cmd.div_start) begin
        div_axis_r <= cmd.div_axis;
        div_cnt_r  <= CNT_W'(POS_W);
        dvd_r      <= s_sum[POS_W-1:0];
        rem_r      <= '0;
        if (s_sum[POS_W]) outside_r <= 1'b1;
      end else if (div_busy_r) begin
        div_cnt_r <= div_cnt_r - CNT_W'(1);
        dvd_r     <= quo;
        rem_r     <= div_ge ? div_sub[RAD_W-1:0] : div_t[RAD_W-1:0];
        if (div_cnt_r == CNT_W'(1)) begin
          if (quo >= POS_W'(len)) begin
            outside_r <= 1'b1;
          end else if (div_axis_r) begin
            cj_r <= quo[IDX_W-1:0];
          end else begin
            ci_r <= quo[IDX_W-1:0];
          end
        end
      end
    end
    if (cmd.link_load) begin
      link_r <= head_rdata;
    end else if (cmd.latch_disk) begin
      link_r <= d_next;
      adx_r  <= adx[POS_W-1:0];
      ady_r  <= ady[POS_W-1:0];
      c_r    <= {1'b0, d_rad} + {1'b0, probe_radius_r};
    end
    if (cmd.sq_x) begin
      prod_r <= mul_p;
    end else if (cmd.sq_y) begin
      acc_r  <= {1'b0, prod_r};
      prod_r <= mul_p;
    end else if (cmd.sq_c) begin
      acc_r  <= acc_r + {1'b0, prod_r};
      prod_r <= mul_p;
    end
    if (cmd.out_load) begin
      out_r.hit    <= hit_r;
      out_r.status <= status_r;
    end
  end

  assign stat.cmd        = cmd_r;
  assign stat.full       = (count_r == LINK_W'(MAX_DISKS));
  assign stat.sweep_last = (sweep_addr_r == CELL_AW'(NCELLS - 1));
  assign stat.div_done   = !div_busy_r;
  assign stat.outside    = outside_r;
  assign stat.nb_end     = (nb_r == NB_COUNT);
  assign stat.nb_ok      = row_ok & col_ok;
  assign stat.link_zero  = (link_r == '0);
  assign stat.is_hit     = acc_r < {1'b0, prod_r};
  assign out_data        = out_r;

endmodule

// ===== rtl/gcdc_ctrl.sv =====
// Controller: sequences clear sweep, cell division, insert and neighbor list walk.
// Depends on gcdc_pkg.
module gcdc_ctrl import gcdc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [4:0] S_INIT   = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_DECODE = 5'd2;
  localparam logic [4:0] S_CLEAR  = 5'd3;
  localparam logic [4:0] S_DIVXW  = 5'd4;
  localparam logic [4:0] S_DIVYW  = 5'd5;
  localparam logic [4:0] S_INSRD  = 5'd6;
  localparam logic [4:0] S_INSWR  = 5'd7;
  localparam logic [4:0] S_NBSEL  = 5'd8;
  localparam logic [4:0] S_HEAD   = 5'd9;
  localparam logic [4:0] S_LINK   = 5'd10;
  localparam logic [4:0] S_DREAD  = 5'd11;
  localparam logic [4:0] S_SQX    = 5'd12;
  localparam logic [4:0] S_SQY    = 5'd13;
  localparam logic [4:0] S_SQC    = 5'd14;
  localparam logic [4:0] S_CMP    = 5'd15;
  localparam logic [4:0] S_DONE   = 5'd16;

  logic [4:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.cmd)
          CMD_CLEAR: begin
            cmd.sweep_init = 1'b1;
            state_nxt = S_CLEAR;
          end
          CMD_INSERT: begin
            if (stat.full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_FULL;
              state_nxt = S_DONE;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt = S_DIVXW;
            end
          end
          CMD_QUERY: begin
            cmd.div_start = 1'b1;
            state_nxt = S_DIVXW;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) state_nxt = S_DONE;
      end
      S_DIVXW: begin
        if (stat.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_axis  = 1'b1;
          state_nxt = S_DIVYW;
        end
      end
      S_DIVYW: begin
        if (stat.div_done) begin
          if (stat.outside) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_OUTSIDE;
            state_nxt = S_DONE;
          end else if (stat.cmd == CMD_INSERT) begin
            state_nxt = S_INSRD;
          end else begin
            state_nxt = S_NBSEL;
          end
        end
      end
      S_INSRD: state_nxt = S_INSWR;
      S_INSWR: begin
        cmd.ins_wr = 1'b1;
        state_nxt = S_DONE;
      end
      S_NBSEL: begin
        // head read address is live here when the neighbor is in range
        if (stat.nb_end) begin
          state_nxt = S_DONE;
        end else if (!stat.nb_ok) begin
          cmd.nb_next = 1'b1;
        end else begin
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        cmd.link_load = 1'b1;
        state_nxt = S_LINK;
      end
      S_LINK: begin
        if (stat.link_zero) begin
          cmd.nb_next = 1'b1;
          state_nxt = S_NBSEL;
        end else begin
          state_nxt = S_DREAD;
        end
      end
      S_DREAD: begin
        cmd.latch_disk = 1'b1;
        state_nxt = S_SQX;
      end
      S_SQX: begin
        cmd.sq_x = 1'b1;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        cmd.sq_y = 1'b1;
        state_nxt = S_SQC;
      end
      S_SQC: begin
        cmd.sq_c = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (stat.is_hit) begin
          cmd.set_hit = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_LINK;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || cmd.out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/grid_cell_disk_collision_core.sv =====
// Uniform grid disk collision core: clear, insert disk, query point.
// Clear sweeps all GRID_SIDE^2 cell heads; a query, and an insert when not full, runs two
// 24-step cell divisions; a query then walks the disk list of each in-range neighbor cell.
// One item at a time; the next item is taken only after the current result enters the output
// register, and that waits while an older result still blocks the register.
// After reset the cell head RAM is swept empty, with in_ready low.
module grid_cell_disk_collision_core import gcdc_pkg::*; #(
  parameter int MAX_DISKS = MAX_DISKS_DEF,
  parameter int GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  gcdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gcdc_dp #(.MAX_DISKS(MAX_DISKS), .GRID_SIDE(GRID_SIDE)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_wr    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule
